// File: sv/gdce_pkg.sv
// ----------------------------------------------------------------------------
// gdce_pkg: shared types and constants of the GDIFF command encoder
// Request codes, word layouts and the command format between the front end
// and the serialiser.
// ----------------------------------------------------------------------------
package gdce_pkg;

    // Request codes of an input word
    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_ADD   = 3'd1;
    localparam logic [2:0] REQ_DATA  = 3'd2;
    localparam logic [2:0] REQ_COPY  = 3'd3;
    localparam logic [2:0] REQ_END   = 3'd4;

    // Offset modes
    localparam logic [1:0] MODE_ABS      = 2'd0;
    localparam logic [1:0] MODE_REL_VER  = 2'd1;
    localparam logic [1:0] MODE_REL_PREV = 2'd2;

    // Fixed stream bytes
    localparam logic [7:0]  MAGIC_FIRST = 8'hd1;
    localparam logic [31:0] MAGIC_REST  = 32'hffd1ff04;
    localparam logic [7:0]  OP_END      = 8'd0;
    localparam logic [7:0]  OP_ADD_MAX  = 8'd246;
    localparam logic [7:0]  OP_ADD_16   = 8'd247;
    localparam logic [7:0]  OP_ADD_32   = 8'd248;
    localparam logic [7:0]  OP_COPY_16  = 8'd249;
    localparam logic [7:0]  OP_COPY_32  = 8'd252;
    localparam logic [7:0]  OP_COPY_64  = 8'd255;

    localparam int unsigned QUEUE_DEPTH = 2;

    // Byte count of the first (offset) field
    typedef enum logic [1:0] {
        ALEN_0 = 2'd0,
        ALEN_2 = 2'd1,
        ALEN_4 = 2'd2,
        ALEN_8 = 2'd3
    } alen_t;

    // Byte count of the second (length) field
    typedef enum logic [1:0] {
        BLEN_0 = 2'd0,
        BLEN_1 = 2'd1,
        BLEN_2 = 2'd2,
        BLEN_4 = 2'd3
    } blen_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] length;
        logic [62:0] offset;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } result_t;

    // Command queued for the serialiser; fields are left-justified,
    // element 7 (or 3) is sent first
    typedef struct packed {
        logic [7:0]      header;
        logic [7:0][7:0] a_bytes;
        alen_t           a_len;
        logic [3:0][7:0] b_bytes;
        blen_t           b_len;
    } cmd_t;

endpackage

// File: sv/gdce_front.sv
// ----------------------------------------------------------------------------
// gdce_front: request classifier
// Accepts request words, tracks stream positions and turns each request into
// one command for the serialiser; unknown request codes are dropped.
// ----------------------------------------------------------------------------
module gdce_front
    import gdce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       accept,
    input  item_t      item,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [1:0]  mode_reg;
    logic [63:0] ver_pos_reg, ver_pos_next;
    logic [63:0] prev_off_reg, prev_off_next;

    logic        rel;
    logic [63:0] off_ext;
    logic [63:0] base;
    logic [63:0] val;
    logic        fit16;
    logic        fit32;
    logic        len_fit8;
    logic        len_fit16;
    logic [63:0] len_ext;

    // Hold configuration and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_ABS;
            ver_pos_reg  <= '0;
            prev_off_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            ver_pos_reg  <= ver_pos_next;
            prev_off_reg <= prev_off_next;
        end
    end

    // Work out the copy offset value and its width class
    always_comb
    begin
        rel     = (mode_reg == MODE_REL_VER) || (mode_reg == MODE_REL_PREV);
        off_ext = {1'b0, item.offset};
        len_ext = {32'b0, item.length};
        base    = (mode_reg == MODE_REL_VER) ? ver_pos_reg : prev_off_reg;
        if (rel)
        begin
            val   = off_ext - base;
            fit16 = (val[63:15] == '0) || (val[63:15] == '1);
            fit32 = (val[63:31] == '0) || (val[63:31] == '1);
        end
        else
        begin
            val   = off_ext;
            fit16 = (val[63:16] == '0);
            fit32 = (val[63:32] == '0);
        end
        len_fit8  = (item.length[31:8] == '0);
        len_fit16 = (item.length[31:16] == '0);
    end

    // Build the command and the next positions
    always_comb
    begin
        cmd           = '0;
        cmd.a_len     = ALEN_0;
        cmd.b_len     = BLEN_0;
        cmd_push      = 1'b0;
        ver_pos_next  = ver_pos_reg;
        prev_off_next = prev_off_reg;
        if (accept)
        begin
            unique case (item.req_type)
                REQ_START:
                begin
                    cmd_push      = 1'b1;
                    cmd.header    = MAGIC_FIRST;
                    cmd.a_bytes   = {MAGIC_REST, 32'b0};
                    cmd.a_len     = ALEN_4;
                    ver_pos_next  = '0;
                    prev_off_next = '0;
                end
                REQ_ADD:
                begin
                    cmd_push     = 1'b1;
                    ver_pos_next = ver_pos_reg + len_ext;
                    if (len_fit8 && (item.length[7:0] <= OP_ADD_MAX))
                    begin
                        cmd.header = item.length[7:0];
                    end
                    else if (len_fit16)
                    begin
                        cmd.header  = OP_ADD_16;
                        cmd.b_bytes = {item.length[15:0], 16'b0};
                        cmd.b_len   = BLEN_2;
                    end
                    else
                    begin
                        cmd.header  = OP_ADD_32;
                        cmd.b_bytes = item.length;
                        cmd.b_len   = BLEN_4;
                    end
                end
                REQ_DATA:
                begin
                    cmd_push   = 1'b1;
                    cmd.header = item.data_byte;
                end
                REQ_COPY:
                begin
                    cmd_push      = 1'b1;
                    ver_pos_next  = ver_pos_reg + len_ext;
                    prev_off_next = off_ext;
                    // Length field: least byte count that holds it
                    if (len_fit8)
                    begin
                        cmd.b_bytes = {item.length[7:0], 24'b0};
                        cmd.b_len   = BLEN_1;
                    end
                    else if (len_fit16)
                    begin
                        cmd.b_bytes = {item.length[15:0], 16'b0};
                        cmd.b_len   = BLEN_2;
                    end
                    else
                    begin
                        cmd.b_bytes = item.length;
                        cmd.b_len   = BLEN_4;
                    end
                    // Offset field and opcode
                    if (fit16)
                    begin
                        cmd.a_bytes = {val[15:0], 48'b0};
                        cmd.a_len   = ALEN_2;
                        cmd.header  = OP_COPY_16 + {6'b0, cmd.b_len} - 8'd1;
                    end
                    else if (fit32)
                    begin
                        cmd.a_bytes = {val[31:0], 32'b0};
                        cmd.a_len   = ALEN_4;
                        cmd.header  = OP_COPY_32 + {6'b0, cmd.b_len} - 8'd1;
                    end
                    else
                    begin
                        cmd.a_bytes = val;
                        cmd.a_len   = ALEN_8;
                        cmd.header  = OP_COPY_64;
                        cmd.b_bytes = item.length;
                        cmd.b_len   = BLEN_4;
                    end
                end
                REQ_END:
                begin
                    cmd_push   = 1'b1;
                    cmd.header = OP_END;
                end
                default:
                begin
                    // Drop unknown request codes
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: sv/gdce_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gdce_cmd_fifo: command queue
// Short queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module gdce_cmd_fifo
    import gdce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

    cmd_t            mem [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW:0]   count_reg, count_next;

    assign full  = (count_reg == (PtrW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/gdce_back.sv
// ----------------------------------------------------------------------------
// gdce_back: byte serialiser
// Walks the head command byte by byte into an output register.
// ----------------------------------------------------------------------------
module gdce_back
    import gdce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    head,
    input  logic    head_empty,
    output logic    head_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    logic [3:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic [3:0] a_cnt;
    logic [3:0] b_cnt;
    logic [2:0] a_k;
    logic [1:0] b_k;
    logic [3:0] idx_m1;
    logic [3:0] b_off;
    logic [7:0] cur_byte;
    logic       last;
    logic       step;

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    // Decode field lengths and pick the current byte
    always_comb
    begin
        unique case (head.a_len)
            ALEN_0: a_cnt = 4'd0;
            ALEN_2: a_cnt = 4'd2;
            ALEN_4: a_cnt = 4'd4;
            ALEN_8: a_cnt = 4'd8;
            default: a_cnt = 4'd0;
        endcase
        unique case (head.b_len)
            BLEN_0: b_cnt = 4'd0;
            BLEN_1: b_cnt = 4'd1;
            BLEN_2: b_cnt = 4'd2;
            BLEN_4: b_cnt = 4'd4;
            default: b_cnt = 4'd0;
        endcase
        idx_m1 = idx_reg - 4'd1;
        b_off  = idx_m1 - a_cnt;
        a_k    = idx_m1[2:0];
        b_k    = b_off[1:0];
        if (idx_reg == 4'd0)
        begin
            cur_byte = head.header;
        end
        else if (idx_reg <= a_cnt)
        begin
            cur_byte = head.a_bytes[~a_k];
        end
        else
        begin
            cur_byte = head.b_bytes[~b_k];
        end
        last = (idx_reg == (a_cnt + b_cnt));
    end

    // Advance when a command waits and the output register is free or being popped
    always_comb
    begin
        step           = !head_empty && (!out_valid_reg || pop);
        head_pop       = step && last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (step)
        begin
            out_next.out_byte    = cur_byte;
            out_next.last_of_run = last;
            out_valid_next       = 1'b1;
            idx_next             = last ? 4'd0 : idx_reg + 4'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output word
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: sv/gdiff_delta_command_encoder.sv
// ----------------------------------------------------------------------------
// gdiff_delta_command_encoder: GDIFF delta command encoder
// Turns start, add, data, copy and end requests into the GDIFF byte stream.
//
//   Channel  Handshake          Payload
//   item     push / full        item_t   (req_type, length, offset, data_byte)
//   result   empty / pop        result_t (out_byte, last_of_run)
//   config   cfg_wr_en          cfg_wr_data (offset mode, 2 bits)
//
// Each known request yields 1 to 13 bytes, one byte per cycle from the serialiser
// while results are popped; data bytes therefore stream at one word per cycle.
// The classifier turns a word combinationally into a command for a two-entry
// command queue; full rises only when that queue holds two commands.
// The output register refills in the cycle it is popped if a command waits.
// Reset clears positions, offset mode, queue and output register.
// ----------------------------------------------------------------------------
module gdiff_delta_command_encoder
    import gdce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  item_t      item,
    output logic       empty,
    input  logic       pop,
    output result_t    result
);

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    cmd_t q_head;

    assign full   = q_full;
    assign accept = push && !q_full;

    gdce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (item),
        .cmd_push    (cmd_push),
        .cmd         (cmd)
    );

    gdce_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    gdce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
